// ----- hdl/ntcut_pkg.sv -----
// Shared types, codes and widths for the NTC under-temperature fault qualifier.
`default_nettype none

package ntcut_pkg;

  localparam int SensorW  = 4;
  localparam int VoltW    = 16;
  localparam int TimeW    = 8;
  localparam int StateW   = 2;
  localparam int EventW   = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int SENSORS_DEFAULT = 16;

  // per-sensor fault machine states
  localparam logic [StateW-1:0] ST_NORMAL    = 2'd0;
  localparam logic [StateW-1:0] ST_SETTING   = 2'd1;
  localparam logic [StateW-1:0] ST_SET       = 2'd2;
  localparam logic [StateW-1:0] ST_RELEASING = 2'd3;

  localparam logic [EventW-1:0] EV_NONE     = 2'd0;
  localparam logic [EventW-1:0] EV_DECLARED = 2'd1;
  localparam logic [EventW-1:0] EV_RELEASED = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_SET_THRESHOLD     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SET_TIME          = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_THRESHOLD = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TIME      = 2'd3;

  typedef struct packed {
    logic [VoltW-1:0] set_threshold;
    logic [TimeW-1:0] set_time;
    logic [VoltW-1:0] release_threshold;
    logic [TimeW-1:0] release_time;
  } ntcut_cfg_t;

  typedef struct packed {
    logic [StateW-1:0] state;
    logic [TimeW-1:0]  set_cnt;
    logic [TimeW-1:0]  rel_cnt;
  } ntcut_entry_t;

  localparam ntcut_entry_t ENTRY_RESET = '{state: ST_NORMAL, set_cnt: '0, rel_cnt: '0};

endpackage

`default_nettype wire

// ----- hdl/ntcut_sample_if.sv -----
// Sample channel: sensor index and thermistor voltage with valid/ready.
`default_nettype none

interface ntcut_sample_if import ntcut_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SensorW-1:0] sensor_index;
  logic [VoltW-1:0]   sample_voltage;

  modport source (output valid, output sensor_index, output sample_voltage, input ready);
  modport sink   (input valid, input sensor_index, input sample_voltage, output ready);
endinterface

`default_nettype wire

// ----- hdl/ntcut_result_if.sv -----
// Result channel: sensor echo, new fault state and event code with valid/ready.
`default_nettype none

interface ntcut_result_if import ntcut_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SensorW-1:0] sensor_echo;
  logic [StateW-1:0]  fault_state;
  logic [EventW-1:0]  event_code;

  modport source (output valid, output sensor_echo, output fault_state, output event_code,
                  input ready);
  modport sink   (input valid, input sensor_echo, input fault_state, input event_code,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/ntc_under_temp_fault_qualifier.sv -----
// Top level: input register, per-sensor state update, result register.
//
// Usage: samples enter on sample_i (sensor_index, sample_voltage) with
// valid/ready; one result per sample leaves on result_o (sensor_echo,
// fault_state, event_code) in the same order. Thresholds and times are
// written through cfg_we_i / cfg_index_i / cfg_wdata_i while no sample is
// in flight; an unknown index is ignored.
// Order: input register, then result register. Throughput: one sample per
// cycle while result_o.ready is high; the sensor state is read and written
// back in the single update stage; a same-sensor sample next cycle sees it.
// Reset: all sensors go to normal with both counters cleared, thresholds
// and times to zero (both sides disabled); no clearing pass is needed.
// Stall: when result_o.ready is low the result register holds, the input
// register fills, and sample_i.ready drops; nothing is lost or repeated.
// A sensor_index at or above NUM_SENSORS returns fault_state normal and
// no event without touching any state.
`default_nettype none

module ntc_under_temp_fault_qualifier import ntcut_pkg::*; #(
  parameter int NUM_SENSORS = SENSORS_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ntcut_sample_if.sink             sample_i,
  ntcut_result_if.source           result_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int IdxW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  ntcut_cfg_t cfg_q;

  logic               s1_valid_q;
  logic [SensorW-1:0] s1_idx_q;
  logic [VoltW-1:0]   s1_volt_q;

  logic               out_valid_q;
  logic [SensorW-1:0] out_echo_q;
  logic [StateW-1:0]  out_state_q;
  logic [EventW-1:0]  out_event_q;

  logic               advance;
  logic               in_accept;
  logic               in_range;
  ntcut_entry_t       cur_entry;
  ntcut_entry_t       nxt_entry;
  logic [EventW-1:0]  nxt_event;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SET_THRESHOLD:     cfg_q.set_threshold     <= cfg_wdata_i[VoltW-1:0];
        CFG_SET_TIME:          cfg_q.set_time          <= cfg_wdata_i[TimeW-1:0];
        CFG_RELEASE_THRESHOLD: cfg_q.release_threshold <= cfg_wdata_i[VoltW-1:0];
        CFG_RELEASE_TIME:      cfg_q.release_time      <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign advance         = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready  = !s1_valid_q || advance;
  assign in_accept       = sample_i.valid && sample_i.ready;
  assign in_range        = (9'(s1_idx_q) < 9'(NUM_SENSORS));

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q  <= sample_i.sensor_index;
      s1_volt_q <= sample_i.sample_voltage;
    end
  end

  ntcut_store #(
    .Depth (NUM_SENSORS),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (advance && in_range),
    .addr_i  (IdxW'(s1_idx_q)),
    .wdata_i (nxt_entry),
    .rdata_o (cur_entry)
  );

  ntcut_fsm u_fsm (
    .cfg_i     (cfg_q),
    .cur_i     (cur_entry),
    .voltage_i (s1_volt_q),
    .nxt_o     (nxt_entry),
    .event_o   (nxt_event)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_echo_q  <= s1_idx_q;
      out_state_q <= in_range ? nxt_entry.state : ST_NORMAL;
      out_event_q <= in_range ? nxt_event : EV_NONE;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.sensor_echo = out_echo_q;
  assign result_o.fault_state = out_state_q;
  assign result_o.event_code  = out_event_q;

endmodule

`default_nettype wire

// ----- hdl/ntcut_store.sv -----
// Per-sensor state store: fault state plus set and release counters.
`default_nettype none

module ntcut_store import ntcut_pkg::*; #(
  parameter int Depth = SENSORS_DEFAULT,
  parameter int IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         we_i,
  input  wire logic [IdxW-1:0] addr_i,
  input  wire ntcut_entry_t wdata_i,
  output ntcut_entry_t      rdata_o
);

  ntcut_entry_t mem_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        mem_q[i] <= ENTRY_RESET;
      end
    end else if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[addr_i];

endmodule

`default_nettype wire

// ----- hdl/ntcut_fsm.sv -----
// Next-state logic for one sensor: set side, then release side.
`default_nettype none

module ntcut_fsm import ntcut_pkg::*; (
  input  wire ntcut_cfg_t      cfg_i,
  input  wire ntcut_entry_t    cur_i,
  input  wire logic [VoltW-1:0] voltage_i,
  output ntcut_entry_t         nxt_o,
  output logic [EventW-1:0]    event_o
);

  logic under;
  logic recovered;
  logic [TimeW-1:0] set_inc;
  logic [TimeW-1:0] rel_inc;

  assign under     = (voltage_i > cfg_i.set_threshold) && (cfg_i.set_time != '0);
  assign recovered = (voltage_i < cfg_i.release_threshold) && (cfg_i.release_time != '0);
  assign set_inc   = (cur_i.set_cnt == '1) ? cur_i.set_cnt : cur_i.set_cnt + 1'b1;
  assign rel_inc   = (cur_i.rel_cnt == '1) ? cur_i.rel_cnt : cur_i.rel_cnt + 1'b1;

  always_comb begin
    logic [StateW-1:0] st;
    logic [TimeW-1:0]  sc;
    logic [TimeW-1:0]  rc;
    logic [EventW-1:0] ev;
    st = cur_i.state;
    sc = cur_i.set_cnt;
    rc = cur_i.rel_cnt;
    ev = EV_NONE;

    if (under) begin
      if (st == ST_NORMAL) begin
        st = ST_SETTING;
        sc = TimeW'(1);
      end else if (st == ST_SETTING) begin
        sc = set_inc;
        if (set_inc >= cfg_i.set_time) begin
          st = ST_SET;
          sc = '0;
          ev = EV_DECLARED;
        end
      end
    end else if (st == ST_SETTING) begin
      st = ST_NORMAL;
    end

    // release side sees the state the set side left, so a fresh declare
    // can move straight on to releasing
    if (recovered) begin
      if (st == ST_SET) begin
        st = ST_RELEASING;
        rc = TimeW'(1);
      end else if (st == ST_RELEASING) begin
        rc = rel_inc;
        if (rel_inc >= cfg_i.release_time) begin
          st = ST_NORMAL;
          rc = '0;
          ev = EV_RELEASED;
        end
      end
    end else if (st == ST_RELEASING) begin
      st = ST_SET;
    end

    nxt_o.state   = st;
    nxt_o.set_cnt = sc;
    nxt_o.rel_cnt = rc;
    event_o       = ev;
  end

endmodule

`default_nettype wire
